// ----- hw/rtl/hrg_pkg.sv -----
// Shared types, constants and functions for the half RGBA to gamma RGBA8 block.
// Holds the pixel structs, the half decode function and the gamma threshold table.
// No dependencies.
`timescale 1ns / 1ps

package hrg_pkg;

  localparam int FIX_W        = 25;               // U1.24, covers 0..2^24
  localparam int FRAC_BITS    = 24;
  localparam int SEARCH_STEPS = 8;                // one step per output bit
  localparam int STAGES       = SEARCH_STEPS + 2; // decode, search steps, output
  localparam int THR_ENTRIES  = 256;

  localparam logic [FIX_W-1:0] ONE_FIX  = FIX_W'(1) << FRAC_BITS;
  localparam logic [4:0]       EXP_SPEC = 5'h1f;
  localparam logic [4:0]       EXP_ONE  = 5'd15;

  typedef struct packed {
    logic [15:0] red_half;
    logic [15:0] green_half;
    logic [15:0] blue_half;
    logic [15:0] alpha_half;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;
    logic [7:0] alpha_byte;
  } pix_out_t;

  typedef struct packed {
    logic [FIX_W-1:0] red;
    logic [FIX_W-1:0] green;
    logic [FIX_W-1:0] blue;
    logic [FIX_W-1:0] alpha;
  } fix_set_t;

  typedef logic [SEARCH_STEPS-1:0]            step_load_t;
  typedef logic [THR_ENTRIES-1:0][FIX_W-1:0] thr_tab_t;

  // Exact decode of a binary16 pattern, clamped to [0,1].
  function automatic logic [FIX_W-1:0] half_to_fix(input logic [15:0] h);
    logic       neg;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] sh;
    logic [FIX_W-1:0] res;
    neg = h[15];
    ex  = h[14:10];
    man = h[9:0];
    sh  = 4'(ex - 5'd1);
    if (ex == EXP_SPEC) begin
      res = (man != 10'd0 || neg) ? '0 : ONE_FIX;
    end else if (neg) begin
      res = '0;
    end else if (ex == 5'd0) begin
      res = FIX_W'(man);
    end else if (ex >= EXP_ONE) begin
      res = ONE_FIX;
    end else begin
      res = FIX_W'({1'b1, man}) << sh;
    end
    return res;
  endfunction

  // Smallest V with V^5 * 510^11 >= (2k-1)^11 * 2^120, i.e. the code k
  // threshold ((k-0.5)/255)^2.2 in U1.24. Entry 0 is never looked at.
  function automatic thr_tab_t build_thr();
    thr_tab_t     tab;
    logic [255:0] c510;
    logic [255:0] rhs;
    logic [255:0] lhs;
    logic [25:0]  lo;
    logic [25:0]  hi;
    logic [25:0]  mid;
    tab  = '0;
    c510 = 256'd1;
    for (int i = 0; i < 11; i++) begin
      c510 = c510 * 256'd510;
    end
    for (int k = 1; k < THR_ENTRIES; k++) begin
      rhs = 256'd1;
      for (int i = 0; i < 11; i++) begin
        rhs = rhs * 256'(2 * k - 1);
      end
      rhs = rhs << 120;
      lo  = 26'd1;
      hi  = 26'(ONE_FIX);
      for (int it = 0; it < 26; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          lhs = c510;
          for (int p = 0; p < 5; p++) begin
            lhs = lhs * 256'(mid);
          end
          if (lhs >= rhs) begin
            hi = mid;
          end else begin
            lo = mid + 26'd1;
          end
        end
      end
      tab[k] = FIX_W'(lo);
    end
    return tab;
  endfunction

  localparam thr_tab_t GAMMA_THR = build_thr();

endpackage

// ----- hw/rtl/hrg_decode.sv -----
// Front stage: decodes the four half channels of a pixel into U1.24 values.
// Depends on hrg_pkg.
`timescale 1ns / 1ps

module hrg_decode (
  input  logic             clk,
  input  logic             load,
  input  hrg_pkg::pix_in_t pixel,
  output hrg_pkg::fix_set_t fix
);
  import hrg_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      fix.red   <= half_to_fix(pixel.red_half);
      fix.green <= half_to_fix(pixel.green_half);
      fix.blue  <= half_to_fix(pixel.blue_half);
      fix.alpha <= half_to_fix(pixel.alpha_half);
    end
  end

endmodule

// ----- hw/rtl/hrg_gamma_lane.sv -----
// One color lane: bitwise binary search of the gamma threshold table,
// one output bit per pipeline stage. Depends on hrg_pkg.
`timescale 1ns / 1ps

module hrg_gamma_lane (
  input  logic                    clk,
  input  hrg_pkg::step_load_t     load,
  input  logic [hrg_pkg::FIX_W-1:0] value,
  output logic [7:0]              code
);
  import hrg_pkg::*;

  logic [FIX_W-1:0] v_q [SEARCH_STEPS-1];
  logic [7:0]       r_q [SEARCH_STEPS];

  for (genvar s = 0; s < SEARCH_STEPS; s++) begin : g_step
    logic [FIX_W-1:0] v_cur;
    logic [7:0]       r_cur;
    logic [7:0]       cand;
    logic             hit;

    if (s == 0) begin : g_first
      assign v_cur = value;
      assign r_cur = '0;
    end else begin : g_rest
      assign v_cur = v_q[s-1];
      assign r_cur = r_q[s-1];
    end

    // try setting this bit; keep it if the value clears that threshold
    assign cand = r_cur | (8'd1 << (SEARCH_STEPS - 1 - s));
    assign hit  = v_cur >= GAMMA_THR[cand];

    always_ff @(posedge clk) begin
      if (load[s]) begin
        r_q[s] <= hit ? cand : r_cur;
      end
    end

    if (s < SEARCH_STEPS - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (load[s]) begin
          v_q[s] <= v_cur;
        end
      end
    end
  end

  assign code = r_q[SEARCH_STEPS-1];

  // a set top bit means the value cleared the code 128 threshold
  a_top_bit: assert property (@(posedge clk)
    load[0] |=> (r_q[0][7] == (v_q[0] >= GAMMA_THR[128])))
    else $error("gamma lane top bit disagrees with threshold");

endmodule

// ----- hw/rtl/hrg_alpha_lane.sv -----
// Alpha lane: round(255*v) on the U1.24 value, then a delay line that keeps
// step with the color lanes. Depends on hrg_pkg.
`timescale 1ns / 1ps

module hrg_alpha_lane (
  input  logic                      clk,
  input  hrg_pkg::step_load_t       load,
  input  logic [hrg_pkg::FIX_W-1:0] value,
  output logic [7:0]                code
);
  import hrg_pkg::*;

  localparam int PROD_W = FIX_W + 8;

  logic [PROD_W-1:0] prod;
  logic [7:0]        lin;
  logic [7:0]        a_q [SEARCH_STEPS];

  // ties round up; value 2^24 lands exactly on 255
  assign prod = PROD_W'(value) * PROD_W'(255) + (PROD_W'(1) << (FRAC_BITS - 1));
  assign lin  = prod[FRAC_BITS +: 8];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      a_q[0] <= lin;
    end
    for (int s = 1; s < SEARCH_STEPS; s++) begin
      if (load[s]) begin
        a_q[s] <= a_q[s-1];
      end
    end
  end

  assign code = a_q[SEARCH_STEPS-1];

endmodule

// ----- hw/rtl/half_rgba_to_gamma_rgba8.sv -----
// Top level: half RGBA pixel in, gamma 2.2 RGBA8 pixel out.
// Depends on hrg_pkg, hrg_decode, hrg_gamma_lane, hrg_alpha_lane.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   in_pixel  (hrg_pkg::pix_in_t)
//   out       output     out_valid / out_ready out_pixel (hrg_pkg::pix_out_t)
//
// One pixel per cycle sustained while out_ready is high; each request goes through
// ten register stages (one decode, eight threshold search, one output), the first
// loaded at the edge that takes it.
// Each stage holds its own valid bit, so empty stages fill while the output stalls.
// Reset clears the valid bits only; no clearing pass is needed.
`timescale 1ns / 1ps

module half_rgba_to_gamma_rgba8 (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hrg_pkg::pix_in_t  in_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output hrg_pkg::pix_out_t out_pixel
);
  import hrg_pkg::*;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] vld_next;
  logic [STAGES-1:0] space;
  logic [STAGES-1:0] go;
  logic [STAGES-1:0] load;

  fix_set_t   fix;
  step_load_t step_load;
  logic [7:0] red_code;
  logic [7:0] green_code;
  logic [7:0] blue_code;
  logic [7:0] alpha_code;

  // a stage can take a request if empty or if its content moves on this cycle
  always_comb begin
    go[STAGES-1]    = out_ready;
    space[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int s = STAGES - 2; s >= 0; s--) begin
      go[s]    = space[s+1];
      space[s] = !vld[s] || space[s+1];
    end
    load[0] = in_valid && space[0];
    for (int s = 1; s < STAGES; s++) begin
      load[s] = vld[s-1] && space[s];
    end
    vld_next = load | (vld & ~go);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_ready  = space[0];
  assign out_valid = vld[STAGES-1];
  assign step_load = load[SEARCH_STEPS:1];

  hrg_decode u_decode (
    .clk   (clk),
    .load  (load[0]),
    .pixel (in_pixel),
    .fix   (fix)
  );

  hrg_gamma_lane u_red (
    .clk   (clk),
    .load  (step_load),
    .value (fix.red),
    .code  (red_code)
  );

  hrg_gamma_lane u_green (
    .clk   (clk),
    .load  (step_load),
    .value (fix.green),
    .code  (green_code)
  );

  hrg_gamma_lane u_blue (
    .clk   (clk),
    .load  (step_load),
    .value (fix.blue),
    .code  (blue_code)
  );

  hrg_alpha_lane u_alpha (
    .clk   (clk),
    .load  (step_load),
    .value (fix.alpha),
    .code  (alpha_code)
  );

  // merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (load[STAGES-1]) begin
      out_pixel.red_byte   <= red_code;
      out_pixel.green_byte <= green_code;
      out_pixel.blue_byte  <= blue_code;
      out_pixel.alpha_byte <= alpha_code;
    end
  end

  a_empty_front_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> in_ready)
    else $error("front stage empty but request refused");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !out_ready |-> !in_ready)
    else $error("request taken while every stage is held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && vld == '0)
    else $error("pipeline not empty after reset");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    vld[STAGES-1] && !out_ready |=> vld[STAGES-1])
    else $error("output dropped without handshake");

endmodule
